// ----- rtl/core/ehp_pkg.sv -----
// shared types and constants of the frame header parser
`default_nettype none
package ehp_pkg;

   // header kinds on the result channel
   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_ETH  = 3'd1;
   localparam logic [2:0] KIND_ARP  = 3'd2;
   localparam logic [2:0] KIND_IP   = 3'd3;
   localparam logic [2:0] KIND_ICMP = 3'd4;
   localparam logic [2:0] KIND_UDP  = 3'd5;

   // ethernet field codes
   localparam logic [3:0] F_ETH_DST   = 4'd0;
   localparam logic [3:0] F_ETH_SRC   = 4'd1;
   localparam logic [3:0] F_ETH_ETYPE = 4'd2;

   // arp field codes
   localparam logic [3:0] F_ARP_HTYPE = 4'd0;
   localparam logic [3:0] F_ARP_PTYPE = 4'd1;
   localparam logic [3:0] F_ARP_HLEN  = 4'd2;
   localparam logic [3:0] F_ARP_PLEN  = 4'd3;
   localparam logic [3:0] F_ARP_OPER  = 4'd4;
   localparam logic [3:0] F_ARP_SHA   = 4'd5;

   // ipv4 field codes
   localparam logic [3:0] F_IP_VER    = 4'd0;
   localparam logic [3:0] F_IP_HLEN   = 4'd1;
   localparam logic [3:0] F_IP_DSCP   = 4'd2;
   localparam logic [3:0] F_IP_ECN    = 4'd3;
   localparam logic [3:0] F_IP_TOS    = 4'd4;
   localparam logic [3:0] F_IP_TLEN   = 4'd5;
   localparam logic [3:0] F_IP_ID     = 4'd6;
   localparam logic [3:0] F_IP_FRAG   = 4'd7;
   localparam logic [3:0] F_IP_FLAGS  = 4'd8;
   localparam logic [3:0] F_IP_TTL    = 4'd9;
   localparam logic [3:0] F_IP_PROTO  = 4'd10;
   localparam logic [3:0] F_IP_CSUM   = 4'd11;
   localparam logic [3:0] F_IP_SRC    = 4'd12;
   localparam logic [3:0] F_IP_DST    = 4'd13;

   // icmp field codes
   localparam logic [3:0] F_ICMP_TYPE    = 4'd0;
   localparam logic [3:0] F_ICMP_CODE    = 4'd1;
   localparam logic [3:0] F_ICMP_CSUM    = 4'd2;
   localparam logic [3:0] F_ICMP_POINTER = 4'd3;
   localparam logic [3:0] F_ICMP_GATEWAY = 4'd4;
   localparam logic [3:0] F_ICMP_ID      = 4'd5;
   localparam logic [3:0] F_ICMP_SEQ     = 4'd6;
   localparam logic [3:0] F_ICMP_UNUSED  = 4'd7;

   // udp field codes
   localparam logic [3:0] F_UDP_SPORT = 4'd0;
   localparam logic [3:0] F_UDP_DPORT = 4'd1;
   localparam logic [3:0] F_UDP_LEN   = 4'd2;
   localparam logic [3:0] F_UDP_CSUM  = 4'd3;

   // header sizes in bytes
   localparam logic [7:0] ETH_BYTES  = 8'd14;
   localparam logic [7:0] ARP_BYTES  = 8'd8;
   localparam logic [7:0] IP_BYTES   = 8'd20;
   localparam logic [7:0] L4_BYTES   = 8'd8;
   localparam logic [7:0] QUOTE_END  = 8'd36;

   localparam logic [15:0] ETYPE_MIN  = 16'h0600;
   localparam logic [15:0] ETYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_ICMP = 8'd1;
   localparam logic [7:0]  PROTO_IPIP = 8'd4;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [3:0]  IP_VERSION = 4'd4;
   localparam logic [5:0]  IP_MIN_HL  = 6'd20;
   localparam logic [15:0] FRAG_MASK  = 16'h1FFF;

   // icmp types
   localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
   localparam logic [7:0] ICMP_UNREACH    = 8'd3;
   localparam logic [7:0] ICMP_QUENCH     = 8'd4;
   localparam logic [7:0] ICMP_REDIRECT   = 8'd5;
   localparam logic [7:0] ICMP_ECHO_REQ   = 8'd8;
   localparam logic [7:0] ICMP_TIME_EXC   = 8'd11;
   localparam logic [7:0] ICMP_PARAM      = 8'd12;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      LYR_ETH, LYR_ARP_FIX, LYR_ARP_ADDR, LYR_IP, LYR_IP_OPT, LYR_ICMP, LYR_UDP, LYR_DONE
   } layer_type;

   typedef enum logic [3:0] {
      JOB_NONE, JOB_ETH, JOB_ARP_FIX, JOB_ARP_BOTH, JOB_ARP_ADDR,
      JOB_IP, JOB_ICMP, JOB_QUOTE, JOB_UDP
   } job_kind_type;

   // one decoded header handed from the byte walker to the field emitter
   typedef struct packed {
      job_kind_type kind;
      logic [3:0]   level;
      logic         has_term;
      logic [3:0]   term_level;
      logic [15:0]  arp_len;
   } job_ctrl_type;

endpackage
`default_nettype wire

// ----- rtl/core/eth_arp_ipv4_icmp_udp_header_parser_top.sv -----
// top level of the ethernet / arp / ipv4 / icmp / udp header parser
// usage
//   req channel: one frame byte per word in network order, req_frame_end on
//   the last byte. rsp channel: one decoded header field per word, then one
//   terminating word (kind none, last_of_frame set) per frame.
//   both channels use valid/stall; a word moves when valid is high and stall low.
// throughput
//   one byte accepted per cycle while req_stall is low. a byte that completes a
//   header goes into the header queue; the emitter's output register then shows
//   its field words on rsp, one per cycle while rsp is not stalled (up to 15
//   words for one byte: 14 ipv4 fields plus the terminator).
//   the emitter's one-word-per-cycle output register sets the field rate; a
//   two-entry header queue decouples it from the byte walker, so req_stall
//   rises only while both queue entries hold headers still being emitted.
// stall
//   a stalled rsp word holds; the emitter keeps its place and the walker keeps
//   taking bytes until the queue fills.
// reset
//   synchronous, active high; the walker waits for an ethernet header, the
//   queue empties and rsp_valid drops. capture bytes hold no reset value.
`default_nettype none
module eth_arp_ipv4_icmp_udp_header_parser_top
   import ehp_pkg::*;
#(
   parameter int MAX_NEST       = 4,
   parameter int ADDR_BYTES_MAX = 8,
   parameter int CAPTURE_DEPTH  = 36
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_header_kind,
   output logic [2:0]  rsp_nest_level,
   output logic [3:0]  rsp_field_code,
   output logic [63:0] rsp_field_value,
   output logic        rsp_too_long_flag,
   output logic        rsp_last_of_frame
);

   localparam int SNAP_W = CAPTURE_DEPTH * 8;
   localparam int QW     = $bits(job_ctrl_type) + SNAP_W;

   // walker to queue
   logic              q_push, q_full;
   job_ctrl_type      push_ctrl;
   logic [SNAP_W-1:0] push_snap;

   // queue to emitter
   logic              q_pop, head_valid;
   logic [QW-1:0]     head_data;
   job_ctrl_type      head_ctrl;
   logic [SNAP_W-1:0] head_snap;

   ehp_front #(
      .MAX_NEST       (MAX_NEST),
      .ADDR_BYTES_MAX (ADDR_BYTES_MAX),
      .CAPTURE_DEPTH  (CAPTURE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_frame_byte (req_frame_byte),
      .req_frame_end  (req_frame_end),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_ctrl         (push_ctrl),
      .q_snap         (push_snap)
   );

   // header queue carries control plus the byte snapshot of the header
   ehp_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  ({push_ctrl, push_snap}),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign head_ctrl = head_data[QW-1 -: $bits(job_ctrl_type)];
   assign head_snap = head_data[SNAP_W-1:0];

   ehp_back #(
      .ADDR_BYTES_MAX (ADDR_BYTES_MAX),
      .CAPTURE_DEPTH  (CAPTURE_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (head_valid),
      .job_ctrl          (head_ctrl),
      .job_snap          (head_snap),
      .job_pop           (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_header_kind   (rsp_header_kind),
      .rsp_nest_level    (rsp_nest_level),
      .rsp_field_code    (rsp_field_code),
      .rsp_field_value   (rsp_field_value),
      .rsp_too_long_flag (rsp_too_long_flag),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   // the walker never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("header queue overflow");

   // the queue is popped only while it holds a header
   assert property (@(posedge clock) disable iff (reset) q_pop |-> head_valid)
      else $error("header queue underflow");

   // kind none appears only as the frame terminator
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_header_kind == KIND_NONE) == rsp_last_of_frame))
      else $error("terminator word mismatch");

   // long address flag only on arp words
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long_flag |-> rsp_header_kind == KIND_ARP)
      else $error("too long flag on non arp word");

endmodule
`default_nettype wire

// ----- rtl/core/ehp_front.sv -----
// byte walker: tracks the header chain and hands finished headers to the queue
`default_nettype none
module ehp_front
   import ehp_pkg::*;
#(
   parameter int MAX_NEST       = 4,
   parameter int ADDR_BYTES_MAX = 8,
   parameter int CAPTURE_DEPTH  = 36
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_frame_byte,
   input  logic                       req_frame_end,
   input  logic                       q_full,
   output logic                       q_push,
   output job_ctrl_type               q_ctrl,
   output logic [CAPTURE_DEPTH*8-1:0] q_snap
);

   localparam int CW = $clog2(CAPTURE_DEPTH);

   layer_type   state_ff, state_in, after_ff, after_in;
   logic [7:0]  bih_ff, bih_in, bih_inc;
   logic [3:0]  chain_ff, chain_in, chain_step;
   logic [5:0]  skip_ff, skip_in;
   logic [15:0] arp_len_ff, arp_len_in;
   logic [1:0]  sec_ff, sec_in, sec_nxt;
   logic        sec_found;
   logic [7:0]  cap_ff [CAPTURE_DEPTH];
   logic [7:0]  cap_nx [CAPTURE_DEPTH];
   logic        take, wr_en, chain_inc;
   logic [8:0]  wr_pos;
   logic [7:0]  cur_len;
   logic [15:0] etype;
   logic [5:0]  hdr_len;
   layer_type   ip_next;
   job_kind_type kind;
   logic [3:0]  job_level;

   assign req_stall = q_full;
   assign take      = req_valid && !q_full;
   assign bih_inc   = bih_ff + 8'd1;
   assign cur_len   = sec_ff[0] ? arp_len_ff[7:0] : arp_len_ff[15:8];

   // capture write, current byte folded in so decisions see it
   always_comb begin
      wr_en  = 1'b0;
      wr_pos = 9'(bih_ff);
      case (state_ff)
         LYR_ETH, LYR_ARP_FIX, LYR_IP, LYR_ICMP, LYR_UDP: wr_en = 1'b1;
         LYR_ARP_ADDR: begin
            wr_en  = (bih_ff < 8'(ADDR_BYTES_MAX));
            wr_pos = 9'(sec_ff) * 9'(ADDR_BYTES_MAX) + 9'(bih_ff);
         end
         default: wr_en = 1'b0;
      endcase
      for (int k = 0; k < CAPTURE_DEPTH; k++) begin
         cap_nx[k] = (wr_en && wr_pos == 9'(k)) ? req_frame_byte : cap_ff[k];
         q_snap[k*8 +: 8] = cap_nx[k];
      end
   end

   assign etype   = {cap_nx[12], cap_nx[13]};
   assign hdr_len = {cap_nx[0][3:0], 2'b00};

   // next nonzero arp address section after the current one
   always_comb begin
      sec_nxt   = 2'd0;
      sec_found = 1'b0;
      for (int s = 3; s >= 1; s--) begin
         if (2'(s) > sec_ff &&
             ((s % 2 == 1) ? arp_len_ff[7:0] : arp_len_ff[15:8]) != 8'd0) begin
            sec_nxt   = 2'(s);
            sec_found = 1'b1;
         end
      end
   end

   always_comb begin
      if (cap_nx[9] == PROTO_ICMP) begin
         ip_next = LYR_ICMP;
      end else if (cap_nx[9] == PROTO_UDP) begin
         ip_next = LYR_UDP;
      end else if (cap_nx[9] == PROTO_IPIP && 32'(chain_ff) < MAX_NEST) begin
         ip_next = LYR_IP;
      end else begin
         ip_next = LYR_DONE;
      end
   end

   // output side: which header completes on this byte
   always_comb begin
      kind      = JOB_NONE;
      job_level = chain_ff;
      case (state_ff)
         LYR_ETH:
            if (bih_inc == ETH_BYTES && etype >= ETYPE_MIN) kind = JOB_ETH;
         LYR_ARP_FIX:
            if (bih_inc == ARP_BYTES) begin
               kind = (cap_nx[4] == 8'd0 && cap_nx[5] == 8'd0) ? JOB_ARP_BOTH : JOB_ARP_FIX;
            end
         LYR_ARP_ADDR:
            if (bih_inc >= cur_len && !sec_found) begin
               kind      = JOB_ARP_ADDR;
               job_level = chain_ff - 4'd1;
            end
         LYR_IP:
            if (bih_inc == IP_BYTES && cap_nx[0][7:4] == IP_VERSION) kind = JOB_IP;
         LYR_ICMP:
            if (bih_inc == L4_BYTES) begin
               kind = JOB_ICMP;
            end else if (bih_inc == QUOTE_END) begin
               kind = JOB_QUOTE;
            end
         LYR_UDP:
            if (bih_inc == L4_BYTES) kind = JOB_UDP;
         default: kind = JOB_NONE;
      endcase
   end

   assign chain_inc  = (kind == JOB_ETH || kind == JOB_ARP_FIX || kind == JOB_ARP_BOTH ||
                        kind == JOB_IP || kind == JOB_ICMP || kind == JOB_UDP);
   assign chain_step = chain_ff + {3'd0, chain_inc};

   assign q_push              = take && (kind != JOB_NONE || req_frame_end);
   assign q_ctrl.kind         = kind;
   assign q_ctrl.level        = job_level;
   assign q_ctrl.has_term     = req_frame_end;
   assign q_ctrl.term_level   = chain_step;
   assign q_ctrl.arp_len      = (state_ff == LYR_ARP_FIX) ? {cap_nx[4], cap_nx[5]} : arp_len_ff;

   // next state
   always_comb begin
      state_in   = state_ff;
      after_in   = after_ff;
      bih_in     = bih_ff;
      chain_in   = chain_step;
      skip_in    = skip_ff;
      arp_len_in = arp_len_ff;
      sec_in     = sec_ff;
      case (state_ff)
         LYR_ETH: begin
            bih_in = bih_inc;
            if (bih_inc == ETH_BYTES) begin
               bih_in = 8'd0;
               if (etype == ETYPE_ARP && etype >= ETYPE_MIN) begin
                  state_in = LYR_ARP_FIX;
               end else if (etype == ETYPE_IPV4) begin
                  state_in = LYR_IP;
               end else begin
                  state_in = LYR_DONE;
               end
            end
         end
         LYR_ARP_FIX: begin
            bih_in = bih_inc;
            if (bih_inc == ARP_BYTES) begin
               bih_in     = 8'd0;
               arp_len_in = {cap_nx[4], cap_nx[5]};
               sec_in     = (cap_nx[4] != 8'd0) ? 2'd0 : 2'd1;
               state_in   = (cap_nx[4] == 8'd0 && cap_nx[5] == 8'd0) ? LYR_DONE : LYR_ARP_ADDR;
            end
         end
         LYR_ARP_ADDR: begin
            bih_in = bih_inc;
            if (bih_inc >= cur_len) begin
               bih_in = 8'd0;
               if (sec_found) begin
                  sec_in = sec_nxt;
               end else begin
                  state_in = LYR_DONE;
               end
            end
         end
         LYR_IP: begin
            bih_in = bih_inc;
            if (bih_inc == IP_BYTES) begin
               bih_in = 8'd0;
               if (cap_nx[0][7:4] != IP_VERSION || ip_next == LYR_DONE) begin
                  state_in = LYR_DONE;
               end else begin
                  skip_in  = (hdr_len > IP_MIN_HL) ? hdr_len - IP_MIN_HL : 6'd0;
                  after_in = ip_next;
                  state_in = (hdr_len > IP_MIN_HL) ? LYR_IP_OPT : ip_next;
               end
            end
         end
         LYR_IP_OPT: begin
            if (skip_ff != 6'd0) skip_in = skip_ff - 6'd1;
            if (skip_ff <= 6'd1) state_in = after_ff;
         end
         LYR_ICMP: begin
            bih_in = bih_inc;
            if (bih_inc == L4_BYTES) begin
               if (!(cap_nx[0] == ICMP_UNREACH || cap_nx[0] == ICMP_QUENCH ||
                     cap_nx[0] == ICMP_REDIRECT || cap_nx[0] == ICMP_TIME_EXC ||
                     cap_nx[0] == ICMP_PARAM)) begin
                  state_in = LYR_DONE;
               end
            end else if (bih_inc == QUOTE_END) begin
               state_in = LYR_DONE;
            end
         end
         LYR_UDP: begin
            bih_in = bih_inc;
            if (bih_inc == L4_BYTES) state_in = LYR_DONE;
         end
         default: state_in = LYR_DONE;
      endcase
      if (req_frame_end) begin
         state_in   = LYR_ETH;
         after_in   = LYR_ETH;
         bih_in     = 8'd0;
         chain_in   = 4'd0;
         skip_in    = 6'd0;
         arp_len_in = 16'd0;
         sec_in     = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= LYR_ETH;
         after_ff   <= LYR_ETH;
         bih_ff     <= 8'd0;
         chain_ff   <= 4'd0;
         skip_ff    <= 6'd0;
         arp_len_ff <= 16'd0;
         sec_ff     <= 2'd0;
      end else if (take) begin
         state_ff   <= state_in;
         after_ff   <= after_in;
         bih_ff     <= bih_in;
         chain_ff   <= chain_in;
         skip_ff    <= skip_in;
         arp_len_ff <= arp_len_in;
         sec_ff     <= sec_in;
      end
   end

   // at most one capture byte written per accepted word
   always_ff @(posedge clock) begin
      if (take && wr_en && wr_pos < 9'(CAPTURE_DEPTH)) begin
         cap_ff[wr_pos[CW-1:0]] <= req_frame_byte;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/ehp_queue.sv -----
// short header queue between the byte walker and the field emitter
`default_nettype none
module ehp_queue
   import ehp_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [PW:0]      cnt_ff;

   assign full       = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

// ----- rtl/core/ehp_back.sv -----
// field emitter: walks one queued header and sends one field word per cycle while rsp is not stalled
`default_nettype none
module ehp_back
   import ehp_pkg::*;
#(
   parameter int ADDR_BYTES_MAX = 8,
   parameter int CAPTURE_DEPTH  = 36
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  job_ctrl_type               job_ctrl,
   input  logic [CAPTURE_DEPTH*8-1:0] job_snap,
   output logic                       job_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_header_kind,
   output logic [2:0]                 rsp_nest_level,
   output logic [3:0]                 rsp_field_code,
   output logic [63:0]                rsp_field_value,
   output logic                       rsp_too_long_flag,
   output logic                       rsp_last_of_frame
);

   logic [7:0]  sb [CAPTURE_DEPTH];
   logic [7:0]  ib [20];
   logic [3:0]  slot_ff, slot_in, hdr_n, total, code;
   logic        fire, last_slot, in_term;
   logic [7:0]  icmp_type;
   logic [2:0]  kind_out;
   logic [3:0]  lvl;
   logic [63:0] value;
   logic        flag;
   logic [1:0]  sec;
   logic [7:0]  sec_len, keep;
   logic [63:0] raw;
   logic [6:0]  shamt;
   logic [15:0] frag;
   logic        valid_ff;
   logic [2:0]  kind_ff, lvl_ff;
   logic [3:0]  code_ff;
   logic [63:0] value_ff;
   logic        flag_ff, last_ff;

   always_comb begin
      for (int k = 0; k < CAPTURE_DEPTH; k++) sb[k] = job_snap[k*8 +: 8];
      for (int k = 0; k < 20; k++) ib[k] = (job_ctrl.kind == JOB_QUOTE) ? sb[k+8] : sb[k];
   end

   assign icmp_type = sb[0];
   assign frag      = {ib[6], ib[7]};

   always_comb begin
      case (job_ctrl.kind)
         JOB_ETH:      hdr_n = 4'd3;
         JOB_ARP_FIX:  hdr_n = 4'd5;
         JOB_ARP_BOTH: hdr_n = 4'd9;
         JOB_ARP_ADDR: hdr_n = 4'd4;
         JOB_IP:       hdr_n = 4'd14;
         JOB_QUOTE:    hdr_n = 4'd14;
         JOB_ICMP:     hdr_n = (icmp_type == ICMP_ECHO_REPLY ||
                                icmp_type == ICMP_ECHO_REQ) ? 4'd5 : 4'd4;
         JOB_UDP:      hdr_n = 4'd4;
         default:      hdr_n = 4'd0;
      endcase
   end

   assign total     = hdr_n + {3'd0, job_ctrl.has_term};
   assign last_slot = (slot_ff == total - 4'd1);
   assign in_term   = (slot_ff >= hdr_n);
   assign fire      = job_valid && (!valid_ff || !rsp_stall);
   assign job_pop   = fire && last_slot;
   assign slot_in   = last_slot ? 4'd0 : slot_ff + 4'd1;

   // field code of this slot
   always_comb begin
      code = slot_ff;
      case (job_ctrl.kind)
         JOB_ARP_ADDR: code = slot_ff + F_ARP_SHA;
         JOB_ICMP:
            if (slot_ff == F_ICMP_POINTER) begin
               if (icmp_type == ICMP_PARAM) begin
                  code = F_ICMP_POINTER;
               end else if (icmp_type == ICMP_REDIRECT) begin
                  code = F_ICMP_GATEWAY;
               end else if (icmp_type == ICMP_ECHO_REPLY || icmp_type == ICMP_ECHO_REQ) begin
                  code = F_ICMP_ID;
               end else begin
                  code = F_ICMP_UNUSED;
               end
            end else if (slot_ff == F_ICMP_GATEWAY) begin
               code = F_ICMP_SEQ;
            end
         default: code = slot_ff;
      endcase
   end

   // arp address: first keep bytes of the section as a big-endian number
   assign sec     = 2'(code - F_ARP_SHA);
   assign sec_len = sec[0] ? job_ctrl.arp_len[7:0] : job_ctrl.arp_len[15:8];
   assign keep    = (sec_len > 8'(ADDR_BYTES_MAX)) ? 8'(ADDR_BYTES_MAX) : sec_len;
   assign shamt   = (7'(ADDR_BYTES_MAX) - 7'(keep)) << 3;

   always_comb begin
      raw = 64'd0;
      for (int s = 0; s < 4; s++) begin
         if (sec == 2'(s)) begin
            for (int j = 0; j < ADDR_BYTES_MAX; j++) begin
               raw = {raw[55:0], sb[s*ADDR_BYTES_MAX + j]};
            end
         end
      end
   end

   always_comb begin
      value = 64'd0;
      flag  = 1'b0;
      case (job_ctrl.kind)
         JOB_ETH: begin
            kind_out = KIND_ETH;
            case (code)
               F_ETH_DST: value = {16'd0, sb[0], sb[1], sb[2], sb[3], sb[4], sb[5]};
               F_ETH_SRC: value = {16'd0, sb[6], sb[7], sb[8], sb[9], sb[10], sb[11]};
               default:   value = {48'd0, sb[12], sb[13]};
            endcase
         end
         JOB_ARP_FIX, JOB_ARP_BOTH, JOB_ARP_ADDR: begin
            kind_out = KIND_ARP;
            case (code)
               F_ARP_HTYPE: value = {48'd0, sb[0], sb[1]};
               F_ARP_PTYPE: value = {48'd0, sb[2], sb[3]};
               F_ARP_HLEN:  value = {56'd0, sb[4]};
               F_ARP_PLEN:  value = {56'd0, sb[5]};
               F_ARP_OPER:  value = {48'd0, sb[6], sb[7]};
               default: begin
                  value = raw >> shamt;
                  flag  = (sec_len > 8'(ADDR_BYTES_MAX));
               end
            endcase
         end
         JOB_IP, JOB_QUOTE: begin
            kind_out = KIND_IP;
            case (code)
               F_IP_VER:   value = {60'd0, ib[0][7:4]};
               F_IP_HLEN:  value = {58'd0, ib[0][3:0], 2'b00};
               F_IP_DSCP:  value = {58'd0, ib[1][7:2]};
               F_IP_ECN:   value = {62'd0, ib[1][1:0]};
               F_IP_TOS:   value = {56'd0, ib[1]};
               F_IP_TLEN:  value = {48'd0, ib[2], ib[3]};
               F_IP_ID:    value = {48'd0, ib[4], ib[5]};
               F_IP_FRAG:  value = {48'd0, frag & FRAG_MASK};
               F_IP_FLAGS: value = {61'd0, frag[15:13]};
               F_IP_TTL:   value = {56'd0, ib[8]};
               F_IP_PROTO: value = {56'd0, ib[9]};
               F_IP_CSUM:  value = {48'd0, ib[10], ib[11]};
               F_IP_SRC:   value = {32'd0, ib[12], ib[13], ib[14], ib[15]};
               default:    value = {32'd0, ib[16], ib[17], ib[18], ib[19]};
            endcase
         end
         JOB_ICMP: begin
            kind_out = KIND_ICMP;
            case (code)
               F_ICMP_TYPE:    value = {56'd0, sb[0]};
               F_ICMP_CODE:    value = {56'd0, sb[1]};
               F_ICMP_CSUM:    value = {48'd0, sb[2], sb[3]};
               F_ICMP_POINTER: value = {56'd0, sb[4]};
               F_ICMP_ID:      value = {48'd0, sb[4], sb[5]};
               F_ICMP_SEQ:     value = {48'd0, sb[6], sb[7]};
               default:        value = {32'd0, sb[4], sb[5], sb[6], sb[7]};
            endcase
         end
         JOB_UDP: begin
            kind_out = KIND_UDP;
            case (code)
               F_UDP_SPORT: value = {48'd0, sb[0], sb[1]};
               F_UDP_DPORT: value = {48'd0, sb[2], sb[3]};
               F_UDP_LEN:   value = {48'd0, sb[4], sb[5]};
               default:     value = {48'd0, sb[6], sb[7]};
            endcase
         end
         default: kind_out = KIND_NONE;
      endcase
      if (in_term) begin
         kind_out = KIND_NONE;
         value    = 64'd0;
         flag     = 1'b0;
      end
   end

   assign lvl = in_term ? job_ctrl.term_level : job_ctrl.level;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         if (fire) slot_ff <= slot_in;
         if (fire) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff  <= kind_out;
         lvl_ff   <= (lvl > 4'd7) ? 3'd7 : lvl[2:0];
         code_ff  <= in_term ? 4'd0 : code;
         value_ff <= value;
         flag_ff  <= flag;
         last_ff  <= in_term;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_header_kind   = kind_ff;
   assign rsp_nest_level    = lvl_ff;
   assign rsp_field_code    = code_ff;
   assign rsp_field_value   = value_ff;
   assign rsp_too_long_flag = flag_ff;
   assign rsp_last_of_frame = last_ff;

endmodule
`default_nettype wire

// ----- dv/tb_eth_arp_ipv4_icmp_udp_header_parser_top.sv -----
// self-checking bench for the frame header parser: predicts decoded field words per byte
`timescale 1ns / 1ps
`default_nettype none
module tb_eth_arp_ipv4_icmp_udp_header_parser_top;
   import ehp_pkg::*;

   localparam int NEST_LIMIT = 4;
   localparam int ADDR_KEEP  = 8;
   localparam int CAP_DEPTH  = 36;
   localparam int IDLE_LIMIT = 2000;

   // one expected field word
   typedef struct {
      logic [2:0]  kind;
      logic [2:0]  level;
      logic [3:0]  code;
      logic [63:0] value;
      logic        too_long;
      logic        last;
   } field_word_type;

   // scoreboard: walks the frame bytes and queues the field words they produce
   class header_scoreboard;
      layer_type   layer;
      int unsigned hdr_pos;
      logic [7:0]  cap [CAP_DEPTH];
      int unsigned level;
      int unsigned opt_left;
      logic [15:0] arp_len;
      int unsigned arp_sec;
      layer_type   after_opt;
      field_word_type pending[$];
      int          errors;

      function new();
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         layer = LYR_ETH;
         hdr_pos = 0;
         level = 0;
         opt_left = 0;
         arp_len = 0;
         arp_sec = 0;
         after_opt = LYR_ETH;
      endfunction

      function void push(logic [2:0] k, int unsigned lv, logic [3:0] c, logic [63:0] v,
                         logic fl = 1'b0, logic ls = 1'b0);
         field_word_type w;
         w.kind = k;
         w.level = (lv > 7) ? 3'd7 : lv[2:0];
         w.code = c;
         w.value = v;
         w.too_long = fl;
         w.last = ls;
         pending.push_back(w);
      endfunction

      function logic [63:0] grab(int unsigned pos, int unsigned n);
         logic [63:0] v;
         v = 0;
         for (int unsigned i = 0; i < n; i++)
            v = (v << 8) | ((pos + i < CAP_DEPTH) ? cap[pos + i] : 8'h00);
         return v;
      endfunction

      function void keep(int unsigned pos, logic [7:0] b);
         if (pos < CAP_DEPTH) cap[pos] = b;
      endfunction

      function void ipv4_fields(int unsigned base, int unsigned lv);
         logic [7:0]  b0;
         logic [7:0]  b1;
         logic [15:0] fo;
         b0 = grab(base, 1);
         b1 = grab(base + 1, 1);
         fo = grab(base + 6, 2);
         push(KIND_IP, lv, F_IP_VER, b0[7:4]);
         push(KIND_IP, lv, F_IP_HLEN, b0[3:0] * 4);
         push(KIND_IP, lv, F_IP_DSCP, b1[7:2]);
         push(KIND_IP, lv, F_IP_ECN, b1[1:0]);
         push(KIND_IP, lv, F_IP_TOS, b1);
         push(KIND_IP, lv, F_IP_TLEN, grab(base + 2, 2));
         push(KIND_IP, lv, F_IP_ID, grab(base + 4, 2));
         push(KIND_IP, lv, F_IP_FRAG, fo & FRAG_MASK);
         push(KIND_IP, lv, F_IP_FLAGS, fo[15:13]);
         push(KIND_IP, lv, F_IP_TTL, grab(base + 8, 1));
         push(KIND_IP, lv, F_IP_PROTO, grab(base + 9, 1));
         push(KIND_IP, lv, F_IP_CSUM, grab(base + 10, 2));
         push(KIND_IP, lv, F_IP_SRC, grab(base + 12, 4));
         push(KIND_IP, lv, F_IP_DST, grab(base + 16, 4));
      endfunction

      function int unsigned sec_len(int unsigned s);
         return s[0] ? arp_len[7:0] : arp_len[15:8];
      endfunction

      // skip empty address sections; emit all four once past the last
      function void arp_next();
         int unsigned n;
         while (arp_sec < 4 && sec_len(arp_sec) == 0) arp_sec++;
         if (arp_sec < 4) return;
         for (int unsigned s = 0; s < 4; s++) begin
            n = sec_len(s);
            push(KIND_ARP, level - 1, F_ARP_SHA + s,
                 grab(s * ADDR_KEEP, (n > ADDR_KEEP) ? ADDR_KEEP : n), n > ADDR_KEEP);
         end
         layer = LYR_DONE;
      endfunction

      function void note_byte(logic [7:0] b, logic fend);
         logic [15:0] et;
         logic [7:0]  t;
         logic [7:0]  b0;
         layer_type   nxt;
         int unsigned lv;
         case (layer)
            LYR_ETH: begin
               keep(hdr_pos, b);
               hdr_pos++;
               if (hdr_pos == ETH_BYTES) begin
                  et = grab(12, 2);
                  hdr_pos = 0;
                  if (et < ETYPE_MIN) layer = LYR_DONE;
                  else begin
                     push(KIND_ETH, level, F_ETH_DST, grab(0, 6));
                     push(KIND_ETH, level, F_ETH_SRC, grab(6, 6));
                     push(KIND_ETH, level, F_ETH_ETYPE, et);
                     level++;
                     if (et == ETYPE_ARP) layer = LYR_ARP_FIX;
                     else if (et == ETYPE_IPV4) layer = LYR_IP;
                     else layer = LYR_DONE;
                  end
               end
            end
            LYR_ARP_FIX: begin
               keep(hdr_pos, b);
               hdr_pos++;
               if (hdr_pos == ARP_BYTES) begin
                  push(KIND_ARP, level, F_ARP_HTYPE, grab(0, 2));
                  push(KIND_ARP, level, F_ARP_PTYPE, grab(2, 2));
                  push(KIND_ARP, level, F_ARP_HLEN, grab(4, 1));
                  push(KIND_ARP, level, F_ARP_PLEN, grab(5, 1));
                  push(KIND_ARP, level, F_ARP_OPER, grab(6, 2));
                  arp_len = grab(4, 2);
                  level++;
                  hdr_pos = 0;
                  arp_sec = 0;
                  layer = LYR_ARP_ADDR;
                  arp_next();
               end
            end
            LYR_ARP_ADDR: begin
               if (arp_sec < 4) begin
                  if (hdr_pos < ADDR_KEEP) keep(arp_sec * ADDR_KEEP + hdr_pos, b);
                  hdr_pos++;
                  if (hdr_pos >= sec_len(arp_sec)) begin
                     arp_sec++;
                     hdr_pos = 0;
                     arp_next();
                  end
               end else layer = LYR_DONE;
            end
            LYR_IP: begin
               keep(hdr_pos, b);
               hdr_pos++;
               if (hdr_pos == IP_BYTES) begin
                  b0 = grab(0, 1);
                  lv = level;
                  hdr_pos = 0;
                  nxt = LYR_DONE;
                  if (b0[7:4] != IP_VERSION) layer = LYR_DONE;
                  else begin
                     ipv4_fields(0, lv);
                     level++;
                     if (cap[9] == PROTO_ICMP) nxt = LYR_ICMP;
                     else if (cap[9] == PROTO_UDP) nxt = LYR_UDP;
                     else if (cap[9] == PROTO_IPIP && lv < NEST_LIMIT) nxt = LYR_IP;
                     if (nxt == LYR_DONE) layer = LYR_DONE;
                     else begin
                        opt_left = (b0[3:0] * 4 > 20) ? b0[3:0] * 4 - 20 : 0;
                        after_opt = nxt;
                        layer = (opt_left != 0) ? LYR_IP_OPT : nxt;
                     end
                  end
               end
            end
            LYR_IP_OPT: begin
               if (opt_left > 0) opt_left--;
               if (opt_left == 0) layer = after_opt;
            end
            LYR_ICMP: begin
               keep(hdr_pos, b);
               hdr_pos++;
               if (hdr_pos == L4_BYTES) begin
                  t = grab(0, 1);
                  push(KIND_ICMP, level, F_ICMP_TYPE, t);
                  push(KIND_ICMP, level, F_ICMP_CODE, grab(1, 1));
                  push(KIND_ICMP, level, F_ICMP_CSUM, grab(2, 2));
                  if (t == ICMP_PARAM) push(KIND_ICMP, level, F_ICMP_POINTER, grab(4, 1));
                  else if (t == ICMP_REDIRECT)
                     push(KIND_ICMP, level, F_ICMP_GATEWAY, grab(4, 4));
                  else if (t == ICMP_ECHO_REPLY || t == ICMP_ECHO_REQ) begin
                     push(KIND_ICMP, level, F_ICMP_ID, grab(4, 2));
                     push(KIND_ICMP, level, F_ICMP_SEQ, grab(6, 2));
                  end else push(KIND_ICMP, level, F_ICMP_UNUSED, grab(4, 4));
                  level++;
                  if (!(t == ICMP_UNREACH || t == ICMP_QUENCH || t == ICMP_REDIRECT ||
                        t == ICMP_TIME_EXC || t == ICMP_PARAM))
                     layer = LYR_DONE;
               end else if (hdr_pos == QUOTE_END) begin
                  ipv4_fields(8, level);
                  layer = LYR_DONE;
               end
            end
            LYR_UDP: begin
               keep(hdr_pos, b);
               hdr_pos++;
               if (hdr_pos == L4_BYTES) begin
                  push(KIND_UDP, level, F_UDP_SPORT, grab(0, 2));
                  push(KIND_UDP, level, F_UDP_DPORT, grab(2, 2));
                  push(KIND_UDP, level, F_UDP_LEN, grab(4, 2));
                  push(KIND_UDP, level, F_UDP_CSUM, grab(6, 2));
                  level++;
                  layer = LYR_DONE;
               end
            end
            default: ;
         endcase
         if (fend) begin
            push(KIND_NONE, level, 4'd0, 64'd0, 1'b0, 1'b1);
            clear_frame();
         end
      endfunction

      function void check_word(field_word_type got);
         field_word_type w;
         if (pending.size() == 0) begin
            $error("unexpected word kind=%0d code=%0d", got.kind, got.code);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (got.kind !== w.kind) begin
            $error("header_kind exp %0d got %0d", w.kind, got.kind); errors++;
         end
         if (got.level !== w.level) begin
            $error("nest_level exp %0d got %0d", w.level, got.level); errors++;
         end
         if (got.code !== w.code) begin
            $error("field_code exp %0d got %0d", w.code, got.code); errors++;
         end
         if (got.value !== w.value) begin
            $error("field_value exp %h got %h", w.value, got.value); errors++;
         end
         if (got.too_long !== w.too_long) begin
            $error("too_long_flag exp %0d got %0d", w.too_long, got.too_long); errors++;
         end
         if (got.last !== w.last) begin
            $error("last_of_frame exp %0d got %0d", w.last, got.last); errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_frame_byte;
   logic        req_frame_end;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_header_kind;
   logic [2:0]  rsp_nest_level;
   logic [3:0]  rsp_field_code;
   logic [63:0] rsp_field_value;
   logic        rsp_too_long_flag;
   logic        rsp_last_of_frame;

   header_scoreboard sb;
   int          idle_cycles;
   int          stall_mode;
   int          burst_left;
   int          items_sent;
   bit          timed_out;
   logic [7:0]  frame_buf[$];

   eth_arp_ipv4_icmp_udp_header_parser_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_frame_byte    (req_frame_byte),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_header_kind   (rsp_header_kind),
      .rsp_nest_level    (rsp_nest_level),
      .rsp_field_code    (rsp_field_code),
      .rsp_field_value   (rsp_field_value),
      .rsp_too_long_flag (rsp_too_long_flag),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side: check each accepted word at the rising edge
   always @(posedge clock) begin
      field_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_header_kind;
         got.level = rsp_nest_level;
         got.code = rsp_field_code;
         got.value = rsp_field_value;
         got.too_long = rsp_too_long_flag;
         got.last = rsp_last_of_frame;
         sb.check_word(got);
      end
   end

   // receiver stall pattern; mode changes now and then, including a no-stall stretch
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 8);
         endcase
      end
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // send one byte; bursts of random length with random gaps between them
   task automatic send_byte(input logic [7:0] b, input logic fend);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_frame_byte <= b;
      req_frame_end <= fend;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b, fend);
      items_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // push the buffered frame; cut shortens it to that many bytes
   task automatic send_frame(input int cut);
      int n;
      n = (cut > 0 && cut < frame_buf.size()) ? cut : frame_buf.size();
      for (int i = 0; i < n; i++) send_byte(frame_buf[i], i == n - 1);
      req_valid <= 1'b0;
   endtask

   task automatic add_rand(input int n);
      repeat (n) frame_buf.push_back($urandom_range(0, 255));
   endtask

   task automatic add_eth(input logic [15:0] et);
      add_rand(12);
      frame_buf.push_back(et[15:8]);
      frame_buf.push_back(et[7:0]);
   endtask

   task automatic add_ip(input logic [3:0] ver, input logic [3:0] ihl, input logic [7:0] proto);
      frame_buf.push_back({ver, ihl});
      add_rand(8);
      frame_buf.push_back(proto);
      add_rand(10);
      if (ihl > 5) add_rand(ihl * 4 - 20);
   endtask

   task automatic add_arp(input logic [7:0] hl, input logic [7:0] pl);
      add_rand(4);
      frame_buf.push_back(hl);
      frame_buf.push_back(pl);
      add_rand(2);
      add_rand(2 * (hl + pl));
   endtask

   task automatic add_icmp(input logic [7:0] t);
      frame_buf.push_back(t);
      add_rand(35);
   endtask

   task automatic add_arp_frame();
      add_eth(ETYPE_ARP);
      add_arp(($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 8'd6,
              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 8'd4);
   endtask

   // header chain with random content and random shape, at times with bad versions or unknown types
   task automatic build_random_frame();
      int  depth;
      logic [7:0] pr;
      frame_buf.delete();
      case ($urandom_range(0, 9))
         0: add_eth($urandom_range(0, 16'h05FF));
         1: add_eth($urandom_range(16'h0600, 16'hFFFF));
         2: add_arp_frame();
         default: begin
            add_eth(ETYPE_IPV4);
            depth = $urandom_range(0, 5);
            for (int i = 0; i < depth; i++)
               add_ip(($urandom_range(0, 15) == 0) ? $urandom_range(0, 15) : IP_VERSION,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 4'd5, PROTO_IPIP);
            case ($urandom_range(0, 3))
               0: pr = PROTO_ICMP;
               1: pr = PROTO_UDP;
               2: pr = $urandom_range(0, 255);
               default: pr = PROTO_ICMP;
            endcase
            add_ip(($urandom_range(0, 15) == 0) ? $urandom_range(0, 15) : IP_VERSION,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 4'd5, pr);
            if (pr == PROTO_ICMP) begin
               case ($urandom_range(0, 7))
                  0: add_icmp(ICMP_ECHO_REPLY);
                  1: add_icmp(ICMP_ECHO_REQ);
                  2: add_icmp(ICMP_UNREACH);
                  3: add_icmp(ICMP_QUENCH);
                  4: add_icmp(ICMP_REDIRECT);
                  5: add_icmp(ICMP_TIME_EXC);
                  6: add_icmp(ICMP_PARAM);
                  default: add_icmp($urandom_range(0, 255));
               endcase
            end else add_rand(8);
         end
      endcase
      add_rand($urandom_range(0, 4));
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_frame_byte = 8'h00;
      req_frame_end = 1'b0;
      rsp_stall = 1'b0;
      stall_mode = 0;
      burst_left = 0;
      idle_cycles = 0;
      items_sent = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: one short frame per special case
      frame_buf.delete(); add_eth(16'h05FF); send_frame(0);          // small ethertype
      frame_buf.delete(); add_eth(16'hFFFF); send_frame(0);          // unknown ethertype
      frame_buf.delete(); add_eth(ETYPE_IPV4);
      add_ip(4'd6, 4'd5, PROTO_UDP); add_rand(8); send_frame(0);     // bad version
      frame_buf.delete(); add_eth(ETYPE_IPV4);
      add_ip(IP_VERSION, 4'd0, 8'd99); send_frame(0);                // ihl zero, unknown proto
      frame_buf.delete(); add_eth(ETYPE_IPV4);
      repeat (4) add_ip(IP_VERSION, 4'd5, PROTO_IPIP); send_frame(0); // nesting bound
      frame_buf.delete(); add_eth(ETYPE_IPV4);
      add_ip(IP_VERSION, 4'd5, PROTO_ICMP); add_icmp(ICMP_PARAM); send_frame(0); // icmp quote
      frame_buf.delete(); add_eth(ETYPE_IPV4);
      add_ip(IP_VERSION, 4'd5, PROTO_ICMP); add_icmp(ICMP_REDIRECT); send_frame(30); // cut inside ipv4
      frame_buf.delete(); add_eth(ETYPE_ARP); add_arp(8'd0, 8'd0); send_frame(0);  // empty addrs
      frame_buf.delete(); add_eth(ETYPE_ARP); add_arp(8'd9, 8'd4); send_frame(0);  // 9-byte hw
      frame_buf.delete(); add_eth(ETYPE_IPV4); send_frame(20);       // short ipv4
      frame_buf.delete(); frame_buf.push_back(8'hFF); send_frame(0); // one-byte frame

      // random frames up to the item budget, some cut short
      while (items_sent < 460) begin
         build_random_frame();
         if ($urandom_range(0, 7) == 0) send_frame($urandom_range(1, frame_buf.size()));
         else send_frame(0);
      end

      req_valid <= 1'b0;
      // drain: wait until every expected word arrived, then a short quiet tail
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end
endmodule
`default_nettype wire
